/* rtl/assert_macros.svh */
// assertion helpers for the reordering window
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/urrw_pkg.sv */
package urrw_pkg;

	localparam int SN_W = 10;
	localparam int WS_W = 10;
	localparam int TK_W = 16;
	localparam int SHORT_SPACE = 32;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_WIN = 2'd1;
	localparam logic [1:0] REG_TICKS = 2'd2;

	localparam logic REQ_PDU = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [SN_W-1:0] seq_num;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic release_valid;
		logic [SN_W-1:0] release_first;
		logic [SN_W-1:0] release_end;
		logic [SN_W-1:0] ur_value;
		logic [SN_W-1:0] uh_value;
		logic [SN_W-1:0] ux_value;
		logic timer_active;
		logic timer_fired;
	} rsp_t;

endpackage

/* rtl/um_receive_reordering_window_unit.sv */
// Reordering window of an unacknowledged-mode receiver. A request (PDU or tick) is taken
// when start is high and busy low; exactly one result follows, shown for one cycle with
// done high, and must be taken then since the receiver cannot stall. The received bitmap
// sits in a one-port synchronous memory read and written one entry per cycle. After reset
// a clearing pass over every bitmap entry holds busy high. A discarded PDU, or a tick that
// does not expire the timer, passes through the read, check and finish states. An accepted
// PDU, or a tick that expires the timer, also walks ur forward, reading each bitmap entry
// before acting on it, and then sweeps the released entries; a PDU that stops the timer
// stays once more in the finish state. busy is low in the cycle that shows the result, so
// the next request can be taken then. The window walk and release sweep set the rate.
`include "assert_macros.svh"
module um_receive_reordering_window_unit #(
	parameter int SEQ_SPACE = 1024,
	parameter int TIMER_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input urrw_pkg::req_t req,
	output logic done,
	output urrw_pkg::rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = $clog2(SEQ_SPACE);
	localparam int SN = urrw_pkg::SN_W;
	localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2, ST_CHK = 3'd3,
		ST_ADV = 3'd4, ST_REL = 3'd5, ST_FIN = 3'd6;

	logic mode_q;
	logic [urrw_pkg::WS_W-1:0] win_q;
	logic [urrw_pkg::TK_W-1:0] ticks_q;

	logic map_mem [SEQ_SPACE];
	logic rd_data;
	logic [AW-1:0] addr;
	logic we, wd;

	logic [2:0] st_q;
	logic [AW:0] clr_q;
	logic [AW-1:0] ur_q, uh_q, ux_q, last_q, x_q, sw_q, first_q;
	logic tr_q, fired_q, acc_q, rv_q, tick_q;
	logic [TIMER_BITS-1:0] left_q;
	logic [AW:0] cnt_q;

	logic [AW:0] m;
	logic [AW-1:0] mmask, w, wmax;
	logic [SN:0] wraw;

	always_comb begin
		m = mode_q ? (AW+1)'(SEQ_SPACE) : (AW+1)'(urrw_pkg::SHORT_SPACE);
		mmask = m[AW-1:0] - AW'(1);
		wmax = AW'(m >> 1);
		wraw = {1'b0, win_q};
		w = (win_q == '0) ? AW'(1) : ((wraw > (SN+1)'(wmax)) ? wmax : AW'(win_q));
	end

	function automatic logic [AW-1:0] relf(input logic [AW-1:0] xv, input logic [AW-1:0] uh,
			input logic [AW-1:0] ww, input logic [AW-1:0] mk);
		logic [AW-1:0] base;
		base = (uh - ww) & mk;
		return (xv - base) & mk;
	endfunction

	logic [AW-1:0] ur_m, uh_m, ux_m, x_m;
	logic [AW-1:0] rx, rur, rux, rur_n, nuh, nur;
	logic discard;
	always_comb begin
		ur_m = ur_q & mmask;
		uh_m = uh_q & mmask;
		ux_m = ux_q & mmask;
		x_m = x_q & mmask;
		rx = relf(x_m, uh_m, w, mmask);
		rur = relf(ur_m, uh_m, w, mmask);
		discard = (rx < rur) || (rd_data && (rur < rx) && (rx < w));
		nuh = (x_m + AW'(1)) & mmask;
		nur = ur_m;
		if (rx >= w && relf(ur_m, nuh, w, mmask) >= w)
			nur = (nuh - w) & mmask;
		rur_n = relf(ur_q, uh_q, w, mmask);
		rux = relf(ux_q, uh_q, w, mmask);
	end

	always_ff @(posedge clk) begin
		if (we)
			map_mem[addr] <= wd;
		rd_data <= map_mem[addr];
	end

	always_comb begin
		addr = '0;
		we = 1'b0;
		wd = 1'b0;
		case (st_q)
			ST_CLR: begin
				addr = clr_q[AW-1:0];
				we = 1'b1;
			end
			ST_IDLE: addr = AW'(req.seq_num) & mmask;
			ST_RD: addr = x_m;
			ST_CHK: begin
				addr = x_m;
				we = !tick_q && !discard;
				wd = 1'b1;
			end
			ST_ADV: addr = ur_q;
			ST_REL: begin
				addr = sw_q;
				we = (sw_q != ur_q) && (cnt_q < m);
			end
			default: addr = ur_q;
		endcase
	end

	assign busy = (st_q != ST_IDLE);
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:2])
			urrw_pkg::REG_MODE: prdata = {31'd0, mode_q};
			urrw_pkg::REG_WIN: prdata = {22'd0, win_q};
			urrw_pkg::REG_TICKS: prdata = {16'd0, ticks_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			win_q <= 10'd512;
			ticks_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				urrw_pkg::REG_MODE: mode_q <= pwdata[0];
				urrw_pkg::REG_WIN: win_q <= pwdata[9:0];
				urrw_pkg::REG_TICKS: ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// adv: read map[ur] in one cycle, act on it in the next
	logic adv_wait_q;
	logic gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			ur_q <= '0; uh_q <= '0; ux_q <= '0;
			last_q <= AW'(1023);
			tr_q <= 1'b0; left_q <= '0;
			done <= 1'b0;
			x_q <= '0; sw_q <= '0; first_q <= '0; cnt_q <= '0;
			fired_q <= 1'b0; acc_q <= 1'b0; rv_q <= 1'b0; tick_q <= 1'b0;
			adv_wait_q <= 1'b0;
			gap_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(SEQ_SPACE - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: if (start) begin
					tick_q <= req.req_type;
					x_q <= AW'(req.seq_num);
					ur_q <= ur_m; uh_q <= uh_m; ux_q <= ux_m;
					left_q <= left_q;
					fired_q <= 1'b0; acc_q <= 1'b0; rv_q <= 1'b0;
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_CHK;
				ST_CHK: begin
					cnt_q <= '0;
					adv_wait_q <= 1'b1;
					if (tick_q) begin
						if (tr_q && left_q <= TIMER_BITS'(1)) begin
							tr_q <= 1'b0; left_q <= '0; fired_q <= 1'b1;
							ur_q <= ux_m;
							st_q <= ST_ADV;
						end else begin
							if (tr_q) left_q <= left_q - 1'b1;
							st_q <= ST_FIN;
						end
					end else if (discard) begin
						st_q <= ST_FIN;
					end else begin
						acc_q <= 1'b1;
						if (rx >= w) uh_q <= nuh;
						ur_q <= nur;
						st_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (adv_wait_q) begin
						adv_wait_q <= 1'b0;
					end else begin
						// map[ur] visible; the just-set entry is written before this read
						if (rd_data && ur_q != uh_q && cnt_q < m) begin
							ur_q <= (ur_q + 1'b1) & mmask;
							cnt_q <= cnt_q + 1'b1;
							adv_wait_q <= 1'b1;
						end else begin
							first_q <= (last_q + 1'b1) & mmask;
							sw_q <= (last_q + 1'b1) & mmask;
							cnt_q <= '0;
							st_q <= ST_REL;
						end
					end
				end
				ST_REL: begin
					if (sw_q != ur_q && cnt_q < m) begin
						sw_q <= (sw_q + 1'b1) & mmask;
						cnt_q <= cnt_q + 1'b1;
						rv_q <= 1'b1;
					end else begin
						if (first_q != ur_q) begin
							rv_q <= 1'b1;
							last_q <= (ur_q - 1'b1) & mmask;
						end
						st_q <= ST_FIN;
						gap_q <= 1'b1;
					end
				end
				default: begin
					if (gap_q && tr_q && !fired_q && (rux <= rur_n || rux > w)) begin
						tr_q <= 1'b0; left_q <= '0;
					end else begin
						if (gap_q && (!tr_q || fired_q) && rur_n < w) begin
							tr_q <= 1'b1;
							left_q <= TIMER_BITS'(ticks_q);
							ux_q <= uh_q;
						end
						gap_q <= 1'b0;
						done <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		rsp.accepted = acc_q;
		rsp.release_valid = rv_q;
		rsp.release_first = rv_q ? SN'(first_q) : '0;
		rsp.release_end = rv_q ? SN'(ur_q) : '0;
		rsp.ur_value = SN'(ur_q);
		rsp.uh_value = SN'(uh_q);
		rsp.ux_value = SN'(ux_q);
		rsp.timer_active = tr_q;
		rsp.timer_fired = fired_q;
	end

	`ASSERT_NEVER(a_no_done_busy_start, clk, arst_n, done && st_q != ST_IDLE)
	`ASSERT_IMPL(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_NEVER(a_fire_pdu, clk, arst_n, done && rsp.timer_fired && rsp.accepted)
endmodule
